/* rtl/soi_pkg.sv */
package soi_pkg;

	// Field and register widths.
	localparam int COUNT_W = 32;
	localparam int STEER_W = 8;
	localparam int DPC_W   = 16;
	localparam int TURN_W  = 20;
	localparam int POS_W   = 48;
	localparam int HEAD_W  = 32;
	localparam int MAG_W   = 48;
	localparam int CFG_W   = 20;
	localparam int CFGI_W  = 2;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 128;

	// CORDIC datapath: Q30 vector, 34 bits signed for headroom.
	localparam int CORDIC_STEPS = 24;
	localparam int CW           = 34;
	localparam int CI_W         = 5;
	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

	// Product and scaling accumulator widths.
	localparam int MUL_W = 32;
	localparam int PROD_W = 64;
	localparam int ACC_W  = 80;
	localparam int SUM_W  = 52;

	// Configuration register indexes.
	localparam logic [CFGI_W-1:0] CFG_DIST_PER_COUNT = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_STEER_NEUTRAL  = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_TURN_PER_STEER = 2'd2;

	// Register reset values.
	localparam logic [DPC_W-1:0]   DPC_RESET     = 16'd1620;
	localparam logic [STEER_W-1:0] NEUTRAL_RESET = 8'd96;
	localparam logic [TURN_W-1:0]  TURN_RESET    = 20'd95444;

	// Arctangent of 2^-i as a binary angle, 2^32 per full turn.
	localparam logic [29:0] ATAN_TAB [0:31] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10680350,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81,
		30'd41,        30'd20,        30'd10,        30'd5,
		30'd3,         30'd1,         30'd1,         30'd0
	};

endpackage

/* rtl/soi_cordic.sv */
module soi_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [soi_pkg::HEAD_W-1:0]        angle,
	output logic                              done,
	output logic signed [soi_pkg::CW-1:0]     cos_val,
	output logic signed [soi_pkg::CW-1:0]     sin_val
);

	localparam logic [soi_pkg::CI_W-1:0] LAST = soi_pkg::CI_W'(soi_pkg::CORDIC_STEPS - 1);

	logic                              busy_q;
	logic                              done_q;
	logic                              flip_q;
	logic [soi_pkg::CI_W-1:0]          i_q;
	logic signed [soi_pkg::CW-1:0]     x_q;
	logic signed [soi_pkg::CW-1:0]     y_q;
	logic signed [soi_pkg::CW-1:0]     z_q;
	logic signed [soi_pkg::CW-1:0]     dx;
	logic signed [soi_pkg::CW-1:0]     dy;
	logic signed [soi_pkg::CW-1:0]     da;
	logic                              flip;
	logic [soi_pkg::HEAD_W-1:0]        folded;

	// Fold the angle into the right half plane; flipped quadrants negate the result.
	always_comb begin
		flip   = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
		folded = flip ? {~angle[31], angle[30:0]} : angle;
	end

	// One micro-rotation per cycle through the shared shifter pair.
	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		da = soi_pkg::CW'(soi_pkg::ATAN_TAB[i_q]);
	end

	// Step counter; done pulses for one cycle after the last rotation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= busy_q && !start && (i_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == LAST) begin
					busy_q <= 1'b0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	// Vector and residual angle.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= soi_pkg::GAIN_Q30;
			y_q    <= '0;
			z_q    <= soi_pkg::CW'($signed(folded));
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[soi_pkg::CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end
		end
	end

	assign done    = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

/* rtl/steered_odometry_integrator_core.sv */
// Channel  Direction  Width  Contents (lowest bit up)
// s_*      in         48     encoder_count[31:0], steer_cmd[39:32], moving[40], zero fill
// m_*      out        128    pos_x[47:0], pos_y[95:48], heading[127:96]
// cfg_*    in         20     distance_per_count, steer_neutral, turn_per_steer_unit
//
// A result is offered after the magnitude and turn products, the heading update, the
// one-rotation-per-cycle CORDIC and the scaled axes, with the shared 32x32 multiplier
// used six times; the next input can be taken in the cycle the result is offered.
// s_tready is high only while the sequencer is idle; a result waits in the output
// register, and the next item may be taken while it is still held.
// arst_n clears the pose and the previous count and returns the configuration registers to their defaults.
module steered_odometry_integrator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// encoder_count, steer_cmd, moving, zero fill
	input  logic [soi_pkg::IN_W-1:0]       s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// pos_x, pos_y, heading
	output logic [soi_pkg::OUT_W-1:0]      m_tdata,
	input  logic                           cfg_we,
	input  logic [soi_pkg::CFGI_W-1:0]     cfg_index,
	input  logic [soi_pkg::CFG_W-1:0]      cfg_data
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MAG    = 4'd1;
	localparam logic [3:0] ST_TURN   = 4'd2;
	localparam logic [3:0] ST_HEAD   = 4'd3;
	localparam logic [3:0] ST_CSTART = 4'd4;
	localparam logic [3:0] ST_CWAIT  = 4'd5;
	localparam logic [3:0] ST_MLO    = 4'd6;
	localparam logic [3:0] ST_MHI    = 4'd7;
	localparam logic [3:0] ST_MADD   = 4'd8;
	localparam logic [3:0] ST_MSAT   = 4'd9;
	localparam logic [3:0] ST_OUT    = 4'd10;

	logic [3:0]                          state_q;
	logic [soi_pkg::DPC_W-1:0]           dpc_q;
	logic [soi_pkg::STEER_W-1:0]         neutral_q;
	logic [soi_pkg::TURN_W-1:0]          tps_q;
	logic [soi_pkg::COUNT_W-1:0]         prev_q;
	logic signed [soi_pkg::POS_W-1:0]    x_q;
	logic signed [soi_pkg::POS_W-1:0]    y_q;
	logic [soi_pkg::HEAD_W-1:0]          head_q;
	logic [soi_pkg::COUNT_W-1:0]         absd_q;
	logic                                neg_q;
	logic [soi_pkg::STEER_W-1:0]         abss_q;
	logic                                sneg_q;
	logic                                moving_q;
	logic [soi_pkg::MAG_W-1:0]           mag_q;
	logic [soi_pkg::MUL_W-1:0]           cmx_q;
	logic [soi_pkg::MUL_W-1:0]           cmy_q;
	logic                                cnx_q;
	logic                                cny_q;
	logic                                comp_q;
	logic [soi_pkg::PROD_W-1:0]          prod_q;
	logic [soi_pkg::ACC_W-1:0]           acc_q;
	logic                                mvalid_q;
	logic [soi_pkg::OUT_W-1:0]           out_q;

	logic [soi_pkg::MUL_W-1:0]           mul_a;
	logic [soi_pkg::MUL_W-1:0]           mul_b;
	logic [soi_pkg::COUNT_W-1:0]         diff;
	logic [soi_pkg::STEER_W:0]           sdiff;
	logic [soi_pkg::MUL_W-1:0]           cm_sel;
	logic [49:0]                         r;
	logic signed [soi_pkg::SUM_W-1:0]    disp;
	logic signed [soi_pkg::SUM_W-1:0]    sum;
	logic signed [soi_pkg::POS_W-1:0]    base;
	logic signed [soi_pkg::POS_W-1:0]    sat;
	logic                                cstart;
	logic                                cdone;
	logic signed [soi_pkg::CW-1:0]       cos_val;
	logic signed [soi_pkg::CW-1:0]       sin_val;
	logic [soi_pkg::CW-1:0]              cos_abs;
	logic [soi_pkg::CW-1:0]              sin_abs;
	logic                                out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = out_q;
	assign cstart   = (state_q == ST_CSTART);
	assign out_free = !mvalid_q || m_tready;

	soi_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cstart),
		.angle   (head_q),
		.done    (cdone),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	// Input differences taken at the accepting edge, and magnitudes of the CORDIC outputs.
	always_comb begin
		diff  = s_tdata[31:0] - prev_q;
		sdiff = {1'b0, s_tdata[39:32]} - {1'b0, neutral_q};
		cos_abs = cos_val[soi_pkg::CW-1] ? soi_pkg::CW'(-cos_val) : soi_pkg::CW'(cos_val);
		sin_abs = sin_val[soi_pkg::CW-1] ? soi_pkg::CW'(-sin_val) : soi_pkg::CW'(sin_val);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		cm_sel = comp_q ? cmy_q : cmx_q;
		case (state_q)
			ST_MAG: begin
				mul_a = absd_q;
				mul_b = soi_pkg::MUL_W'(dpc_q);
			end
			ST_TURN: begin
				mul_a = soi_pkg::MUL_W'(abss_q);
				mul_b = soi_pkg::MUL_W'(tps_q);
			end
			ST_MLO: begin
				mul_a = soi_pkg::MUL_W'(mag_q[23:0]);
				mul_b = cm_sel;
			end
			ST_MHI: begin
				mul_a = soi_pkg::MUL_W'(mag_q[47:24]);
				mul_b = cm_sel;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Signed displacement and saturating accumulate.
	always_comb begin
		r    = acc_q[79:30];
		disp = (neg_q ^ (comp_q ? cny_q : cnx_q)) ? -$signed({2'b00, r}) : $signed({2'b00, r});
		base = comp_q ? y_q : x_q;
		sum  = soi_pkg::SUM_W'(base) + disp;
		if (sum[soi_pkg::SUM_W-1:soi_pkg::POS_W-1] == '0 ||
		    sum[soi_pkg::SUM_W-1:soi_pkg::POS_W-1] == '1) begin
			sat = sum[soi_pkg::POS_W-1:0];
		end else if (sum[soi_pkg::SUM_W-1]) begin
			sat = {1'b1, {(soi_pkg::POS_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(soi_pkg::POS_W-1){1'b1}}};
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q     <= soi_pkg::DPC_RESET;
			neutral_q <= soi_pkg::NEUTRAL_RESET;
			tps_q     <= soi_pkg::TURN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				soi_pkg::CFG_DIST_PER_COUNT: dpc_q     <= cfg_data[soi_pkg::DPC_W-1:0];
				soi_pkg::CFG_STEER_NEUTRAL:  neutral_q <= cfg_data[soi_pkg::STEER_W-1:0];
				soi_pkg::CFG_TURN_PER_STEER: tps_q     <= cfg_data[soi_pkg::TURN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and pose state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			prev_q   <= '0;
			x_q      <= '0;
			y_q      <= '0;
			head_q   <= '0;
			comp_q   <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			// The held result leaves unless a new one is loaded in the same cycle.
			if (m_tready && state_q != ST_OUT) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						prev_q  <= s_tdata[31:0];
						state_q <= ST_MAG;
					end
				end
				ST_MAG:    state_q <= ST_TURN;
				ST_TURN:   state_q <= ST_HEAD;
				ST_HEAD: begin
					if (moving_q) begin
						if (sneg_q) begin
							head_q <= head_q + prod_q[31:0];
						end else begin
							head_q <= head_q - prod_q[31:0];
						end
					end
					state_q <= ST_CSTART;
				end
				ST_CSTART: state_q <= ST_CWAIT;
				ST_CWAIT: begin
					if (cdone) begin
						comp_q  <= 1'b0;
						state_q <= ST_MLO;
					end
				end
				ST_MLO:    state_q <= ST_MHI;
				ST_MHI:    state_q <= ST_MADD;
				ST_MADD:   state_q <= ST_MSAT;
				ST_MSAT: begin
					if (comp_q) begin
						y_q     <= sat;
						state_q <= ST_OUT;
					end else begin
						x_q     <= sat;
						comp_q  <= 1'b1;
						state_q <= ST_MLO;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						mvalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: multiplier product, operands, scaling accumulator and output register.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && s_tvalid) begin
			neg_q    <= diff[31];
			absd_q   <= diff[31] ? -diff : diff;
			sneg_q   <= sdiff[soi_pkg::STEER_W];
			abss_q   <= sdiff[soi_pkg::STEER_W] ? soi_pkg::STEER_W'(-sdiff)
			                                    : sdiff[soi_pkg::STEER_W-1:0];
			moving_q <= s_tdata[40];
		end
		if (state_q == ST_TURN) begin
			mag_q <= prod_q[soi_pkg::MAG_W-1:0];
		end
		if (state_q == ST_CWAIT && cdone) begin
			cmx_q <= cos_abs[soi_pkg::MUL_W-1:0];
			cmy_q <= sin_abs[soi_pkg::MUL_W-1:0];
			cnx_q <= cos_val[soi_pkg::CW-1];
			cny_q <= sin_val[soi_pkg::CW-1];
		end
		if (state_q == ST_MHI) begin
			acc_q <= soi_pkg::ACC_W'(prod_q);
		end
		if (state_q == ST_MADD) begin
			acc_q <= acc_q + {prod_q[55:0], 24'd0};
		end
		if (state_q == ST_OUT && out_free) begin
			out_q <= {head_q, y_q, x_q};
		end
	end

endmodule

/* rtl/soi_checker.sv */
module soi_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [soi_pkg::OUT_W-1:0]      m_tdata
);

	// A held result keeps its value until its transaction completes.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("held result changed before it was taken");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	// A result never appears the cycle after its input is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind steered_odometry_integrator_core soi_checker u_soi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
